// ===== hdl/ppmhp_pkg.sv =====
// Shared constants for the PPM P6 header parser: phase codes, status codes, character codes, widths and limits.
package ppmhp_pkg;

    // parser phase codes
    localparam logic [3:0] PH_MAGIC0  = 4'd0;
    localparam logic [3:0] PH_MAGIC1  = 4'd1;
    localparam logic [3:0] PH_PRE     = 4'd2;
    localparam logic [3:0] PH_COMMENT = 4'd3;
    localparam logic [3:0] PH_WIDTH   = 4'd4;
    localparam logic [3:0] PH_SP1     = 4'd5;
    localparam logic [3:0] PH_HEIGHT  = 4'd6;
    localparam logic [3:0] PH_SP2     = 4'd7;
    localparam logic [3:0] PH_MAXV    = 4'd8;
    localparam logic [3:0] PH_PAYLOAD = 4'd9;
    localparam logic [3:0] PH_ERROR   = 4'd10;

    // result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SHORT  = 3'd1;
    localparam logic [2:0] ST_MAGIC  = 3'd2;
    localparam logic [2:0] ST_HEADER = 3'd3;
    localparam logic [2:0] ST_TRUNC  = 3'd4;

    // character codes
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // byte counter and header length widths
    localparam int COUNT_W = 40;
    localparam int HL_W    = COUNT_W + 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam int MIN_FILE_LEN = 16;

    // maxval accumulator
    localparam int MAXV_W = 9;
    localparam logic [MAXV_W-1:0] MAXV_CAP  = 9'd256;
    localparam logic [MAXV_W-1:0] MAXV_WANT = 9'd255;

    // field widths of the result item
    localparam int STATUS_W = 3;
    localparam int DIM_OUT_W = 16;
    localparam int OFFSET_W = 32;

endpackage

// ===== hdl/ppm_p6_header_parser.sv =====
// Top level of the PPM P6 header parser: byte stream in, one status item per file out.
// Result path: the final byte of a file is taken into the input register, and the parse
//   logic then loads the result register from it.
// Throughput: one byte per cycle; the input side stalls only while a finished result waits
//   and the next final byte reaches the parse stage.
// Reset: rst_n clears all parser state and both valid flags at once; no clearing pass.
module ppm_p6_header_parser
    import ppmhp_pkg::*;
#(
    parameter int DIM_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last byte of the file
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // [2:0] status, [18:3] width, [34:19] height,
                                        // [66:35] payload_offset, [71:67] zero
);

    localparam int ACC_W  = DIM_BITS + 1;       // holds up to 2^DIM_BITS (the cap)
    localparam int PROD_W = 2 * DIM_BITS;
    localparam int NEED_W = PROD_W + 2;
    localparam int SUM_W  = (NEED_W + 1 > HL_W + 1) ? NEED_W + 1 : HL_W + 1;
    localparam logic [ACC_W-1:0] DIM_CAP = {1'b1, {DIM_BITS{1'b0}}};

    // ------------------------------------------------------------------
    // Decimal accumulate with cap: acc*10 + digit, clamped.
    // ------------------------------------------------------------------
    function automatic logic [ACC_W-1:0] dim_accum(input logic [ACC_W-1:0] acc,
                                                   input logic [7:0] c);
        logic [ACC_W+3:0] v;
        begin
            v = ({3'b000, acc, 1'b0} + {1'b0, acc, 3'b000})
                + (ACC_W + 4)'(c - CH_ZERO);
            dim_accum = (v > (ACC_W + 4)'(DIM_CAP)) ? DIM_CAP : v[ACC_W-1:0];
        end
    endfunction

    function automatic logic [MAXV_W-1:0] maxv_accum(input logic [MAXV_W-1:0] acc,
                                                     input logic [7:0] c);
        logic [MAXV_W+3:0] v;
        begin
            v = ({3'b000, acc, 1'b0} + {1'b0, acc, 3'b000})
                + (MAXV_W + 4)'(c - CH_ZERO);
            maxv_accum = (v > (MAXV_W + 4)'(MAXV_CAP)) ? MAXV_CAP : v[MAXV_W-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;

    // a byte moves on unless it is a final byte and the result slot is still full
    assign advance = in_valid_reg && (!in_last_reg || !m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    logic [3:0]         phase_reg, phase_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [ACC_W-1:0]   width_acc_reg, width_acc_next;
    logic [ACC_W-1:0]   height_acc_reg, height_acc_next;
    logic [MAXV_W-1:0]  maxval_acc_reg, maxval_acc_next;
    logic [HL_W-1:0]    header_len_reg, header_len_next;
    logic [2:0]         error_code_reg, error_code_next;

    logic is_ws;
    logic is_digit;
    logic [7:0] c;

    assign c        = in_byte_reg;
    assign is_ws    = c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    assign is_digit = c inside {[CH_ZERO:CH_NINE]};

    always_comb
    begin
        phase_next      = phase_reg;
        width_acc_next  = width_acc_reg;
        height_acc_next = height_acc_reg;
        maxval_acc_next = maxval_acc_reg;
        header_len_next = header_len_reg;
        error_code_next = error_code_reg;
        byte_count_next = (byte_count_reg != COUNT_MAX) ? byte_count_reg + 1'b1
                                                        : byte_count_reg;
        case (phase_reg)
            PH_MAGIC0:
            begin
                if (c == CH_P)
                    phase_next = PH_MAGIC1;
                else
                begin
                    phase_next      = PH_ERROR;
                    error_code_next = ST_MAGIC;
                end
            end
            PH_MAGIC1:
            begin
                if (c == CH_SIX)
                    phase_next = PH_PRE;
                else
                begin
                    phase_next      = PH_ERROR;
                    error_code_next = ST_MAGIC;
                end
            end
            PH_PRE:
            begin
                if (is_ws)
                    phase_next = PH_PRE;
                else if (c == CH_HASH)
                    phase_next = PH_COMMENT;
                else if (is_digit)
                begin
                    width_acc_next = dim_accum(width_acc_reg, c);
                    phase_next     = PH_WIDTH;
                end
                else
                begin
                    phase_next      = PH_ERROR;
                    error_code_next = ST_HEADER;
                end
            end
            PH_COMMENT:
            begin
                if (c == CH_LF)
                    phase_next = PH_PRE;
            end
            PH_WIDTH:
            begin
                if (is_digit)
                    width_acc_next = dim_accum(width_acc_reg, c);
                else if (is_ws)
                    phase_next = PH_SP1;
                else
                begin
                    phase_next      = PH_ERROR;
                    error_code_next = ST_HEADER;
                end
            end
            PH_SP1:
            begin
                if (is_ws)
                    phase_next = PH_SP1;
                else if (is_digit)
                begin
                    height_acc_next = dim_accum(height_acc_reg, c);
                    phase_next      = PH_HEIGHT;
                end
                else
                begin
                    phase_next      = PH_ERROR;
                    error_code_next = ST_HEADER;
                end
            end
            PH_HEIGHT:
            begin
                if (is_digit)
                    height_acc_next = dim_accum(height_acc_reg, c);
                else if (is_ws)
                    phase_next = PH_SP2;
                else
                begin
                    phase_next      = PH_ERROR;
                    error_code_next = ST_HEADER;
                end
            end
            PH_SP2:
            begin
                if (is_ws)
                    phase_next = PH_SP2;
                else if (is_digit)
                begin
                    maxval_acc_next = maxv_accum(maxval_acc_reg, c);
                    phase_next      = PH_MAXV;
                end
                else
                begin
                    phase_next      = PH_ERROR;
                    error_code_next = ST_HEADER;
                end
            end
            PH_MAXV:
            begin
                if (is_digit)
                    maxval_acc_next = maxv_accum(maxval_acc_reg, c);
                else if (is_ws && width_acc_reg != '0 && height_acc_reg != '0
                         && !width_acc_reg[DIM_BITS] && !height_acc_reg[DIM_BITS]
                         && maxval_acc_reg == MAXV_WANT)
                begin
                    header_len_next = {1'b0, byte_count_reg} + 1'b1;
                    phase_next      = PH_PAYLOAD;
                end
                else
                begin
                    phase_next      = PH_ERROR;
                    error_code_next = ST_HEADER;
                end
            end
            PH_PAYLOAD:
            begin
                phase_next = PH_PAYLOAD;
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC0;
            byte_count_reg <= '0;
            width_acc_reg  <= '0;
            height_acc_reg <= '0;
            maxval_acc_reg <= '0;
            header_len_reg <= '0;
            error_code_reg <= ST_OK;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                // end of file: start over for the next one
                phase_reg      <= PH_MAGIC0;
                byte_count_reg <= '0;
                width_acc_reg  <= '0;
                height_acc_reg <= '0;
                maxval_acc_reg <= '0;
                header_len_reg <= '0;
                error_code_reg <= ST_OK;
            end
            else
            begin
                phase_reg      <= phase_next;
                byte_count_reg <= byte_count_next;
                width_acc_reg  <= width_acc_next;
                height_acc_reg <= height_acc_next;
                maxval_acc_reg <= maxval_acc_next;
                header_len_reg <= header_len_next;
                error_code_reg <= error_code_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload size: w*h then *3, one register each. Runs every cycle; the
    // dimensions are final once the height field ends, and the maxval field
    // plus its trailing space give at least four bytes before the payload.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] prod_reg;
    logic [NEED_W-1:0] need_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= width_acc_reg[DIM_BITS-1:0] * height_acc_reg[DIM_BITS-1:0];
        need_reg <= {prod_reg, 1'b0} + NEED_W'(prod_reg);
    end

    // ------------------------------------------------------------------
    // Result of the final byte
    // ------------------------------------------------------------------
    logic [2:0]           status_next;
    logic [SUM_W-1:0]     end_pos;
    logic [DIM_BITS+DIM_OUT_W-1:0] width_ext, height_ext;
    logic [DIM_OUT_W-1:0] width_res, height_res;
    logic [OFFSET_W-1:0]  offset_res;

    assign end_pos = SUM_W'(header_len_next) + SUM_W'(need_reg);

    always_comb
    begin
        if (byte_count_next < COUNT_W'(MIN_FILE_LEN))
            status_next = ST_SHORT;
        else if (phase_next == PH_ERROR)
            status_next = error_code_next;
        else if (phase_next != PH_PAYLOAD)
            status_next = ST_HEADER;
        else if (end_pos > SUM_W'(byte_count_next))
            status_next = ST_TRUNC;
        else
            status_next = ST_OK;
    end

    assign width_ext  = {{DIM_OUT_W{1'b0}}, width_acc_next[DIM_BITS-1:0]};
    assign height_ext = {{DIM_OUT_W{1'b0}}, height_acc_next[DIM_BITS-1:0]};
    assign width_res  = width_ext[DIM_OUT_W-1:0];
    assign height_res = height_ext[DIM_OUT_W-1:0];
    // saturate the offset to 32 bits
    assign offset_res = (header_len_next[HL_W-1:OFFSET_W] != '0) ? {OFFSET_W{1'b1}}
                                                               : header_len_next[OFFSET_W-1:0];

    logic                 out_valid_reg;
    logic [2:0]           out_status_reg;
    logic [DIM_OUT_W-1:0] out_width_reg;
    logic [DIM_OUT_W-1:0] out_height_reg;
    logic [OFFSET_W-1:0]  out_offset_reg;
    logic                 load_result;

    assign load_result = advance && in_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            out_status_reg <= status_next;
            if (status_next == ST_OK)
            begin
                out_width_reg  <= width_res;
                out_height_reg <= height_res;
                out_offset_reg <= offset_res;
            end
            else
            begin
                out_width_reg  <= '0;
                out_height_reg <= '0;
                out_offset_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_offset_reg, out_height_reg, out_width_reg,
                            out_status_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_payload_header_sane: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> width_acc_reg != '0 && height_acc_reg != '0
            && !width_acc_reg[DIM_BITS] && !height_acc_reg[DIM_BITS]
            && maxval_acc_reg == MAXV_WANT)
        else $error("payload phase reached with an invalid header");

    a_stall_only_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |-> in_last_reg && out_valid_reg && !m_axis_tready)
        else $error("parse stage stalled without a pending result");

    a_ok_has_dims: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == ST_OK |-> out_width_reg != '0
            || DIM_BITS > DIM_OUT_W)
        else $error("ok result with zero width");

    a_fail_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_OK |-> out_width_reg == '0
            && out_height_reg == '0 && out_offset_reg == '0)
        else $error("failed result carries nonzero fields");

    a_reset_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> phase_reg == PH_MAGIC0 && byte_count_reg == '0)
        else $error("parser state not cleared after final byte");

endmodule
